// ===== design/iefe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iefe_pkg
// Shared types, constants and edge tables of the edge fraction encoder.
// ----------------------------------------------------------------------------
package iefe_pkg;

	localparam int SAMPLE_BITS_DEF = 32;
	localparam int FIELD_BITS      = 32;
	localparam int NUM_CORNERS     = 8;
	localparam int NUM_EDGES       = 12;
	localparam int EDGE_BITS       = 4;
	localparam int CODE_BITS       = 7;
	localparam int QUOT_BITS       = 7;

	localparam logic [CODE_BITS-1:0] CODE_BASE = 7'd35;
	localparam logic [CODE_BITS-1:0] CODE_BAD  = 7'd92;
	localparam logic [CODE_BITS-1:0] CODE_SUB  = 7'd33;

	// corner at each end of every cube edge
	localparam int EDGE_A [NUM_EDGES] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
	localparam int EDGE_B [NUM_EDGES] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

	// per-edge result leaving a lane
	typedef struct packed {
		logic                 hit;
		logic [QUOT_BITS-1:0] quot;
	} lane_res_t;

	// edges this cube owns, from its boundary flags
	function automatic logic [NUM_EDGES-1:0] owned_edges(input logic fx, input logic fy,
		input logic fz);
		logic [NUM_EDGES-1:0] m;
		m = '0;
		m[0] = 1'b1;
		m[3] = 1'b1;
		m[8] = 1'b1;
		if (fx) begin
			m[1] = 1'b1;
			m[9] = 1'b1;
		end
		if (fy) begin
			m[4] = 1'b1;
			m[7] = 1'b1;
		end
		if (fz) begin
			m[2]  = 1'b1;
			m[11] = 1'b1;
		end
		if (fx && fz) m[10] = 1'b1;
		if (fx && fy) m[5] = 1'b1;
		if (fy && fz) m[6] = 1'b1;
		return m;
	endfunction

	// printable code from the quotient, avoiding the backslash
	function automatic logic [CODE_BITS-1:0] frac_code(input logic [QUOT_BITS-1:0] q);
		logic [CODE_BITS-1:0] c;
		c = CODE_BASE + q;
		return (c == CODE_BAD) ? CODE_SUB : c;
	endfunction

endpackage
`default_nettype wire

// ===== design/isosurface_edge_fraction_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A cube passes the lane input, scale and divider registers, then the merge
// register. Throughput: one cube per cycle while output is free; a cube
// with n crossings holds the output for n results, one per cycle while tready.
// All NUM_EDGES edge lanes and the output merge advance together under the single enable adv.
// Reset clears all valid bits and iso_level to 0; payload registers are not reset.
// ----------------------------------------------------------------------------
// isosurface_edge_fraction_encoder_core
// Per-cube edge crossing fractions encoded as printable codes.
// ----------------------------------------------------------------------------
module isosurface_edge_fraction_encoder_core import iefe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,       // iso_level
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [255:0] s_axis_tdata,   // corner_0 .. corner_7, 32 bits each
	input  wire logic [2:0]   s_axis_tuser,   // first_in_x, first_in_y, first_in_z
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // fraction_code[6:0], edge_number[10:7]
	output logic              m_axis_tlast
);

	localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [FIELD_BITS-1:0]  level_q;
	logic [SAMPLE_BITS-1:0] level_b;
	logic [SAMPLE_BITS-1:0] corner_b [NUM_CORNERS];
	logic [NUM_EDGES-1:0]   own;
	lane_res_t              res [NUM_EDGES];
	logic                   adv;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_valid) begin
			level_q <= cfg_data;
		end
	end

	// offset-binary samples so unsigned compares keep the order
	always_comb begin
		level_b = SAMPLE_BITS'(level_q) ^ SIGN;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			corner_b[i] = SAMPLE_BITS'(s_axis_tdata[FIELD_BITS*i +: FIELD_BITS]) ^ SIGN;
		end
		own = owned_edges(s_axis_tuser[0], s_axis_tuser[1], s_axis_tuser[2])
			& {NUM_EDGES{s_axis_tvalid}};
	end

	assign s_axis_tready = adv;

	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
		iefe_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.own   (own[e]),
			.a     (corner_b[EDGE_A[e]]),
			.b     (corner_b[EDGE_B[e]]),
			.level (level_b),
			.res   (res[e])
		);
	end

	iefe_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.adv          (adv)
	);

`ifndef SYNTHESIS
	// empty output stage always takes the next cube
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// codes stay printable and skip the backslash
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[6:0] >= CODE_SUB) && (m_axis_tdata[6:0] <= 7'd124)
			&& (m_axis_tdata[6:0] != CODE_BAD))
		else $error("fraction code out of range");

	// edge number within the cube
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:7] < 4'd12)
		else $error("edge number out of range");

	// a stalled non-last result keeps the cube from being replaced
	a_hold_cube: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("new cube taken while results pending");
`endif

endmodule
`default_nettype wire

// ===== design/iefe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iefe_lane
// One edge: crossing test, scale by 90 and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module iefe_lane import iefe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic                   own,
	input  wire logic [SAMPLE_BITS-1:0] a,
	input  wire logic [SAMPLE_BITS-1:0] b,
	input  wire logic [SAMPLE_BITS-1:0] level,
	output lane_res_t                   res
);

	localparam int DW = SAMPLE_BITS + QUOT_BITS;

	logic                   own_s1;
	logic [SAMPLE_BITS-1:0] num_s1, den_s1;
	logic                   num_neg_s1, den_neg_s1;
	logic                   num_neg, den_neg;
	logic [SAMPLE_BITS-1:0] num, den;

	// magnitudes and signs of level-a and b-a
	always_comb begin
		num_neg = level < a;
		num     = num_neg ? a - level : level - a;
		den_neg = b < a;
		den     = den_neg ? a - b : b - a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_s1 <= 1'b0;
		end else if (adv) begin
			own_s1 <= own && (a != b);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1     <= num;
			den_s1     <= den;
			num_neg_s1 <= num_neg;
			den_neg_s1 <= den_neg;
		end
	end

	// divider pipeline, index 0 is stage 2
	logic                   hit_s [QUOT_BITS+1];
	logic [DW-1:0]          rem_s [QUOT_BITS+1];
	logic [SAMPLE_BITS-1:0] dvs_s [QUOT_BITS+1];
	logic [QUOT_BITS-1:0]   quo_s [QUOT_BITS+1];
	logic [DW-1:0]          num_w;

	assign num_w = DW'(num_s1);

	// crossing when 0 <= num/den < 1; numerator scaled by 90
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s[0] <= 1'b0;
		end else if (adv) begin
			hit_s[0] <= own_s1 && !(num_s1 != '0 && num_neg_s1 != den_neg_s1)
				&& (num_s1 < den_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= (num_w << 6) + (num_w << 4) + (num_w << 3) + (num_w << 1);
			dvs_s[0] <= den_s1;
			quo_s[0] <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		localparam int K = QUOT_BITS - 1 - j;
		logic [DW-1:0] dsh;
		logic          ge;

		always_comb begin
			dsh = DW'(dvs_s[j]) << K;
			ge  = rem_s[j] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hit_s[j+1] <= 1'b0;
			end else if (adv) begin
				hit_s[j+1] <= hit_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				dvs_s[j+1] <= dvs_s[j];
				quo_s[j+1] <= quo_s[j] | (ge ? QUOT_BITS'(1) << K : '0);
			end
		end
	end

	assign res = {hit_s[QUOT_BITS], quo_s[QUOT_BITS]};

endmodule
`default_nettype wire

// ===== design/iefe_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iefe_merge
// Collects the lane results of one cube and sends them highest edge first.
// ----------------------------------------------------------------------------
module iefe_merge import iefe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lane_res_t   res [NUM_EDGES],
	input  wire logic        m_axis_tready,
	output logic             m_axis_tvalid,
	output logic [15:0]      m_axis_tdata,  // fraction_code[6:0], edge_number[10:7]
	output logic             m_axis_tlast,
	output logic             adv
);

	logic [NUM_EDGES-1:0]                pend_q;
	logic [NUM_EDGES-1:0][CODE_BITS-1:0] code_q;
	logic [EDGE_BITS-1:0]                sel;
	logic                                single;

	// highest pending edge
	always_comb begin
		sel = '0;
		for (int e = 0; e < NUM_EDGES; e++) begin
			if (pend_q[e]) sel = EDGE_BITS'(e);
		end
	end

	// load a new cube once the current one is empty or on its last transfer
	always_comb begin
		single        = (pend_q & (pend_q - 1'b1)) == '0;
		m_axis_tvalid = pend_q != '0;
		m_axis_tlast  = single;
		m_axis_tdata  = {5'b0, sel, code_q[sel]};
		adv           = !m_axis_tvalid || (single && m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (adv) begin
			for (int e = 0; e < NUM_EDGES; e++) pend_q[e] <= res[e].hit;
		end else if (m_axis_tready) begin
			pend_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < NUM_EDGES; e++) code_q[e] <= frac_code(res[e].quot);
		end
	end

endmodule
`default_nettype wire
